[sv/sorted_insertion_buffer_macros.svh]
// Assertion macros shared by the sorted insertion buffer RTL.
// No dependencies; included by sorted_insertion_buffer, the module that carries assertions.
`ifndef SORTED_INSERTION_BUFFER_MACROS_SVH
`define SORTED_INSERTION_BUFFER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SIB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SIB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sib_pkg.sv]
// Shared types and codes of the sorted insertion buffer.
// No dependencies; imported by sib_cell, sorted_insertion_buffer and the testbench.
package sib_pkg;

    localparam int unsigned DataWidth = 32;

    typedef logic signed [DataWidth-1:0] t_data;

    typedef enum logic [1:0] {
        KIND_DONE  = 2'd0,
        KIND_FULL  = 2'd1,
        KIND_ELEM  = 2'd2,
        KIND_EMPTY = 2'd3
    } t_kind;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_READ   = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;   // insert the broadcast value this cycle
        logic rot;   // rotate the occupied entries down by one place
    } t_cell_ctl;

endpackage

[sv/sorted_insertion_buffer.sv]
// Sorted insertion buffer: a chain of compare-and-shift cells holding signed
// values in ascending order. Depends on sib_pkg, sib_cell and the macro header.
//
// Usage:
// The input channel (i_valid / o_ready) carries an item with i_mode and
// i_value. Mode insert places the value ahead of the first stored value
// that is greater than or equal to it and returns one status item: done,
// or full when the store already holds CAPACITY values (store unchanged).
// Mode read streams every stored value in ascending order, one item per
// cycle, with o_last on the final one; an empty store gives one empty item.
// The output channel (o_valid / i_ready) is a single output register.
// The first result shows in the cycle after acceptance. Inserts sustain one
// item per cycle while the receiver keeps up, since every cell compares with
// the broadcast value and shifts in the same cycle. A read holds the block
// until every stored value is out, the chain rotating one place per emitted
// value; the input is not ready during that time. When the receiver stalls
// the output register holds its item and the chain pauses with it.
// Reset (synchronous, active low) empties the store and clears the output
// valid; cell contents are not cleared and are never read before written.
`include "sorted_insertion_buffer_macros.svh"

module sorted_insertion_buffer
    import sib_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_mode,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic        [1:0]  o_kind,
    output logic signed [31:0] o_item,
    output logic               o_last
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    t_state          r_state;
    t_state          n_state;
    logic   [CW-1:0] r_count;
    logic   [CW-1:0] n_count;
    logic   [CW-1:0] r_rd;      // places already emitted during a read
    logic   [CW-1:0] n_rd;
    logic            r_out_valid;
    logic            n_out_valid;
    t_kind           r_kind;
    t_kind           n_kind;
    t_data           r_item;
    t_data           n_item;
    logic            r_last;
    logic            n_last;

    t_data           w_value [CAPACITY];
    logic            w_lt    [CAPACITY];
    t_cell_ctl       w_ctl;

    logic            out_load;
    logic            in_acc;
    logic            full;
    logic            rd_start;
    logic            rd_step;
    logic            rd_done;
    logic   [CW-1:0] top_idx;

    // The output register takes a new item whenever it is empty or drained.
    assign out_load = !r_out_valid || i_ready;
    assign o_ready  = (r_state == ST_IDLE) && out_load;
    assign in_acc   = i_valid && o_ready;
    assign full     = (r_count == CW'(CAPACITY));
    assign top_idx  = r_count - CW'(1);

    assign w_ctl.ins = in_acc && (i_mode == MODE_INSERT) && !full;
    assign rd_start  = in_acc && (i_mode == MODE_READ) && (r_count != '0);
    assign rd_step   = (r_state == ST_READ) && out_load;
    assign rd_done   = (r_rd == top_idx);
    assign w_ctl.rot = rd_start || rd_step;

    // The chain: each cell sees its lower neighbor for an insert shift and
    // its upper neighbor for a read rotation. The topmost occupied cell takes
    // the bottom value, so rotating once per stored value restores the order.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_data rot_src;
        t_data prev_value;
        logic  prev_lt;

        if (g == 0) begin : g_first
            assign prev_value = i_value;
            assign prev_lt    = 1'b1;
        end else begin : g_rest
            assign prev_value = w_value[g-1];
            assign prev_lt    = w_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_top
            assign rot_src = w_value[0];
        end else begin : g_mid
            assign rot_src = (CW'(g) == top_idx) ? w_value[0] : w_value[g+1];
        end

        sib_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_occ        (r_count > CW'(g)),
            .i_ins_value  (i_value),
            .i_prev_value (prev_value),
            .i_prev_lt    (prev_lt),
            .i_rot_value  (rot_src),
            .o_value      (w_value[g]),
            .o_lt         (w_lt[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd        = r_rd;
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_item      = r_item;
        n_last      = r_last;

        if (in_acc) begin
            n_out_valid = 1'b1;
            n_last      = 1'b1;
            n_item      = '0;
            if (i_mode == MODE_INSERT) begin
                if (full) begin
                    n_kind = KIND_FULL;
                end else begin
                    n_kind  = KIND_DONE;
                    n_count = r_count + CW'(1);
                end
            end else if (r_count == '0) begin
                n_kind = KIND_EMPTY;
            end else begin
                n_kind = KIND_ELEM;
                n_item = w_value[0];
                n_last = (r_count == CW'(1));
                if (r_count != CW'(1)) begin
                    n_state = ST_READ;
                    n_rd    = CW'(1);
                end
            end
        end else if (rd_step) begin
            n_out_valid = 1'b1;
            n_kind      = KIND_ELEM;
            n_item      = w_value[0];
            n_last      = rd_done;
            if (rd_done) begin
                n_state = ST_IDLE;
            end else begin
                n_rd = r_rd + CW'(1);
            end
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd        <= n_rd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_item <= n_item;
        r_last <= n_last;
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_kind;
    assign o_item  = r_item;
    assign o_last  = r_last;

    `SIB_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "count above capacity")
    `SIB_ASSERT_NEXT(a_insert_count, i_clk, i_rst_n, w_ctl.ins, r_count == $past(r_count) + CW'(1), "insert did not bump count")
    `SIB_ASSERT_NOW(a_read_blocks, i_clk, i_rst_n, r_state == ST_READ, !o_ready, "input ready during read")
    `SIB_ASSERT_NOW(a_read_ptr, i_clk, i_rst_n, r_state == ST_READ, (r_rd != '0) && (r_rd < r_count), "read position out of range")

endmodule

[sv/sib_cell.sv]
// One storage cell of the sorted chain: holds one value, compares it with
// the broadcast insert value and shifts or rotates with its neighbors. Uses sib_pkg.
module sib_cell
    import sib_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occ,        // this place holds a stored value
    input  t_data     i_ins_value,  // value being inserted
    input  t_data     i_prev_value, // value of the lower neighbor
    input  logic      i_prev_lt,    // lower neighbor stays in place
    input  t_data     i_rot_value,  // value that moves in on a rotation
    output t_data     o_value,
    output logic      o_lt
);

    t_data r_value;
    t_data n_value;

    // Stored value strictly below the new one keeps its place.
    assign o_lt    = i_occ && (r_value < i_ins_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (o_lt) begin
                n_value = r_value;
            end else if (i_prev_lt) begin
                n_value = i_ins_value;
            end else begin
                n_value = i_prev_value;
            end
        end else if (i_ctl.rot) begin
            n_value = i_rot_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

[test/testbench.sv]
// Self-checking testbench for sorted_insertion_buffer: a directed table, then random
// inserts and read-outs, checked against a shadow copy of the sorted store.
// Depends on sib_pkg and the sorted_insertion_buffer RTL; reads no files.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sib_pkg::*;

    localparam int Capacity    = 16;
    localparam int DirRows     = 24;
    localparam int RandomItems = 246;
    localparam int CalmItems   = 40;
    localparam int LongHold    = 100;
    localparam int IdleLimit   = 1000;
    localparam int TailCycles  = 40;

    // One result of the block, as the shadow store predicts it.
    typedef struct {
        t_kind kind;
        t_data item;
        logic  last;
    } t_result;

    // One row of the directed table. Rows marked typed carry their single
    // status result; all other rows are checked against the shadow store.
    typedef struct {
        t_mode mode;
        t_data value;
        bit    typed;
        t_kind kind;
    } t_row;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_mode  = 1'b0;
    logic [31:0] i_value = '0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [31:0] o_item;
    logic        o_last;

    t_data   shadow_list[$];   // sorted copy of the stored values
    t_result due_results[$];   // results still owed by the block, oldest first
    int      fail_count = 0;
    bit      calm       = 1'b0;   // no idling on either side
    bit      long_hold  = 1'b0;   // asks the receiver for one long hold-off

    // Fill the store with extremes, equal values and both bit patterns, read
    // it back on the way, then hit the full store and read it out again.
    t_row dir_rows [DirRows] = '{
        '{MODE_READ,   32'sh0000_0000, 1'b1, KIND_EMPTY},
        '{MODE_INSERT, 32'sh0000_0000, 1'b1, KIND_DONE},
        '{MODE_INSERT, 32'sh7FFF_FFFF, 1'b1, KIND_DONE},
        '{MODE_INSERT, 32'sh8000_0000, 1'b1, KIND_DONE},
        '{MODE_INSERT, 32'sh0000_0000, 1'b1, KIND_DONE},
        '{MODE_INSERT, 32'shFFFF_FFFF, 1'b1, KIND_DONE},
        '{MODE_READ,   32'sh0000_0000, 1'b0, KIND_DONE},
        '{MODE_INSERT, 32'sh5555_5555, 1'b1, KIND_DONE},
        '{MODE_INSERT, 32'shAAAA_AAAA, 1'b1, KIND_DONE},
        '{MODE_INSERT, 32'sh0000_0001, 1'b1, KIND_DONE},
        '{MODE_INSERT, 32'sh7FFF_FFFF, 1'b1, KIND_DONE},
        '{MODE_INSERT, 32'sh8000_0000, 1'b1, KIND_DONE},
        '{MODE_READ,   32'shFFFF_FFFF, 1'b0, KIND_DONE},
        '{MODE_INSERT, 32'shFFFF_FFFE, 1'b1, KIND_DONE},
        '{MODE_INSERT, 32'sh7FFF_FFFE, 1'b1, KIND_DONE},
        '{MODE_INSERT, 32'sh8000_0001, 1'b1, KIND_DONE},
        '{MODE_INSERT, 32'sh0000_0064, 1'b1, KIND_DONE},
        '{MODE_INSERT, 32'shFFFF_FF9C, 1'b1, KIND_DONE},
        '{MODE_INSERT, 32'sh0000_0005, 1'b1, KIND_DONE},
        '{MODE_INSERT, 32'sh0000_002A, 1'b1, KIND_FULL},
        '{MODE_READ,   32'sh0000_0000, 1'b0, KIND_DONE},
        '{MODE_INSERT, 32'sh8000_0000, 1'b1, KIND_FULL},
        '{MODE_INSERT, 32'sh7FFF_FFFF, 1'b1, KIND_FULL},
        '{MODE_READ,   32'sh5555_5555, 1'b0, KIND_DONE}
    };

    sorted_insertion_buffer #(
        .CAPACITY(Capacity)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_mode (i_mode),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_kind (o_kind),
        .o_item (o_item),
        .o_last (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Applies one accepted item to the shadow store and lists its results.
    // A new value goes in front of every stored value that is not smaller.
    function automatic void shadow_apply(input t_mode mode, input t_data value,
                                         output t_result res[$]);
        int pos;
        res = {};
        if (mode == MODE_INSERT) begin
            if (shadow_list.size() >= Capacity) begin
                res.push_back('{KIND_FULL, '0, 1'b1});
            end else begin
                pos = 0;
                while (pos < shadow_list.size() && shadow_list[pos] < value)
                    pos++;
                shadow_list.insert(pos, value);
                res.push_back('{KIND_DONE, '0, 1'b1});
            end
        end else if (shadow_list.size() == 0) begin
            res.push_back('{KIND_EMPTY, '0, 1'b1});
        end else begin
            foreach (shadow_list[k])
                res.push_back('{KIND_ELEM, shadow_list[k], k == shadow_list.size() - 1});
        end
    endfunction

    // Offers one item and holds it until the block takes it. Valid stays high
    // on return so that a following item can go out back to back.
    task automatic offer_item(input t_mode mode, input t_data value,
                              input bit typed, input t_kind kind);
        t_result res[$];
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_value <= value;
        @(posedge i_clk);
        while (o_ready !== 1'b1)
            @(posedge i_clk);
        shadow_apply(mode, value, res);
        if (typed) begin
            due_results.push_back('{kind, '0, 1'b1});
        end else begin
            foreach (res[k])
                due_results.push_back(res[k]);
        end
    endtask

    // Random gap on the input side, skipped once the run has gone calm.
    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic t_data random_value();
        case ($urandom_range(0, 5))
            0: random_value = 32'sh8000_0000;
            1: random_value = 32'sh7FFF_FFFF;
            2: random_value = t_data'($urandom_range(0, 4)) - 32'sd2;
            default: random_value = t_data'($urandom);
        endcase
    endfunction

    // Receiver: bursts of ready and stall, one long hold-off on request.
    initial begin : ready_gen
        int n;
        @(posedge i_clk);
        forever begin
            n = $urandom_range(1, 18);
            if (long_hold) begin
                i_ready <= 1'b0;
                repeat (LongHold) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (calm) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_ready <= ($urandom_range(0, 2) != 0);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // Compares every accepted result with the oldest one still owed.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (due_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: kind %0d item %0d last %0d",
                             o_kind, $signed(o_item), o_last);
            end else begin
                want = due_results.pop_front();
                if (o_kind !== want.kind || o_item !== want.item || o_last !== want.last) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected kind %0d item %0d last %0d, got kind %0d item %0d last %0d",
                                 want.kind, want.item, want.last,
                                 o_kind, $signed(o_item), o_last);
                end
            end
        end
    end

    // Ends the run when neither channel has moved for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IdleLimit) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle = 0;
            else
                idle++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        t_mode mode;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            sender_gap();
            offer_item(dir_rows[r].mode, dir_rows[r].value, dir_rows[r].typed,
                       dir_rows[r].kind);
        end

        // The store is full from here on: inserts must be turned away and
        // read-outs stream all entries, under random back-pressure until the run goes calm.
        for (int r = 0; r < RandomItems; r++) begin
            if (r == 60)
                long_hold = 1'b1;
            if (r == 120) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (due_results.size() != 0)
                    @(posedge i_clk);
            end
            if (r == RandomItems - CalmItems)
                calm = 1'b1;
            sender_gap();
            mode = t_mode'($urandom_range(0, 1));
            offer_item(mode, random_value(), 1'b0, KIND_DONE);
        end
        i_valid <= 1'b0;

        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);

        if (fail_count == 0 && due_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

[sorted_insertion_buffer.f]
+incdir+sv
sv/sib_pkg.sv
sv/sib_cell.sv
sv/sorted_insertion_buffer.sv
test/testbench.sv
